[rtl/cd_pkg.sv]
// ----------------------------------------------------------------------------
// cd_pkg
// Shared types and codes for the circular deque: request modes, result
// status codes, the data select and the controller command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package cd_pkg;

  // Field widths fixed by the interface
  localparam int CAP_W  = 5;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;

  // Capacity after reset (clipped to the store depth in the datapath)
  localparam int CAP_RESET = 16;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PEEK_BACK  = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVER  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDER = 2'd2;

  // Source of the result word
  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_MEM,
    SEL_ONES
  } data_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic op_go;     // request accepted: update pointers, write or read store
    logic out_load;  // capture the result into the output register
  } cd_cmd_t;

endpackage

`default_nettype wire

[rtl/circular_deque.sv]
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed words in a circular slot memory with a
// configurable capacity.
// ----------------------------------------------------------------------------
// Each request (push/pop/peek at front or back) yields exactly one result
// carrying the word read, a status (ok, overflow, underflow) and the empty,
// full and occupancy flags after the request. The slot memory is accessed
// and pointers move on the cycle a request is accepted, and the registered
// memory read is captured into the output register on the next. A new
// request is taken while the previous result is being handed off, but not
// while a request is still waiting for its result capture (state S_READ).
// Writing cfg_wdata sets the capacity (0 reads as 1, values above DEPTH clip to
// DEPTH) and empties the deque; write it only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque
  import cd_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [MODE_W-1:0]    in_mode,
  input  wire logic [WORD_BITS-1:0] in_value,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [WORD_BITS-1:0] out_data,
  output logic      [STAT_W-1:0]    out_status,
  output logic                      out_is_empty,
  output logic                      out_is_full,
  output logic      [CAP_W-1:0]     out_occupancy,
  // capacity register
  input  wire logic                 cfg_we,
  input  wire logic [CAP_W-1:0]     cfg_wdata
);

  cd_cmd_t cmd;

  cd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cd_dpath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full),
    .out_occupancy (out_occupancy)
  );

endmodule

`default_nettype wire

[rtl/cd_ctrl.sv]
// ----------------------------------------------------------------------------
// cd_ctrl
// Controller for the circular deque. Sequences each request through the
// store access and result capture, and owns both channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_ctrl
  import cd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output cd_cmd_t      cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // Take a request when idle and the output register is free or being drained
  assign in_ready     = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign cmd.op_go    = in_valid && in_ready;
  assign cmd.out_load = (state_r == S_READ);
  assign out_valid    = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.op_go) state_nxt = S_READ;
      S_READ: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/cd_dpath.sv]
// ----------------------------------------------------------------------------
// cd_dpath
// Datapath for the circular deque: slot memory, head/tail pointers, word
// count, capacity register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cd_dpath
  import cd_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cd_cmd_t              cmd,
  input  wire logic [MODE_W-1:0]    in_mode,
  input  wire logic [WORD_BITS-1:0] in_value,
  input  wire logic                 cfg_we,
  input  wire logic [CAP_W-1:0]     cfg_wdata,
  output logic      [WORD_BITS-1:0] out_data,
  output logic      [STAT_W-1:0]    out_status,
  output logic                      out_is_empty,
  output logic                      out_is_full,
  output logic      [CAP_W-1:0]     out_occupancy
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW    = (IDX_W > CAP_W) ? IDX_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_INIT =
    CAP_W'((DEPTH < CAP_RESET) ? DEPTH : CAP_RESET);

  // Wrap forward within the capacity in use
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
    logic [AW:0] inc;
    logic [AW:0] cap_x;
    inc   = {{(AW+1-IDX_W){1'b0}}, i} + 1'b1;
    cap_x = {{(AW+1-CAP_W){1'b0}}, cap};
    return (inc >= cap_x) ? '0 : inc[IDX_W-1:0];
  endfunction

  // Wrap backward within the capacity in use
  function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
    logic [AW:0] capm1;
    capm1 = {{(AW+1-CAP_W){1'b0}}, cap} - 1'b1;
    return (i == '0) ? capm1[IDX_W-1:0] : i - 1'b1;
  endfunction

  logic [WORD_BITS-1:0] mem [DEPTH];

  logic [CAP_W-1:0] capacity_r, capacity_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CAP_W-1:0] count_r, count_nxt;

  logic [WORD_BITS-1:0] rd_data_r;
  data_sel_t            sel_r, sel_nxt;
  logic [STAT_W-1:0]    stat_r, stat_nxt;

  logic [WORD_BITS-1:0] out_data_r;
  logic [STAT_W-1:0]    out_status_r;
  logic                 out_empty_r;
  logic                 out_full_r;
  logic [CAP_W-1:0]     out_occ_r;

  logic             empty;
  logic             full;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [CAP_W-1:0] cap_sat;

  assign empty = (count_r == '0);
  assign full  = (count_r >= capacity_r);

  // Saturate a written capacity into 1..DEPTH
  always_comb begin
    cap_sat = cfg_wdata;
    if (cfg_wdata == '0) begin
      cap_sat = CAP_W'(1);
    end else if (int'(cfg_wdata) > DEPTH) begin
      cap_sat = CAP_W'(DEPTH);
    end
  end

  // Request decode and pointer update
  always_comb begin
    capacity_nxt = capacity_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    sel_nxt      = sel_r;
    stat_nxt     = stat_r;
    wr_en        = 1'b0;
    wr_addr      = '0;
    rd_addr      = ((in_mode == MODE_POP_FRONT) || (in_mode == MODE_PEEK_FRONT))
                   ? head_r : tail_r;

    if (cfg_we) begin
      capacity_nxt = cap_sat;
      head_nxt     = '0;
      tail_nxt     = '0;
      count_nxt    = '0;
    end else if (cmd.op_go) begin
      sel_nxt  = SEL_ZERO;
      stat_nxt = STAT_OK;
      unique case (in_mode) inside
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (full) begin
            stat_nxt = STAT_OVER;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
            if (empty) begin
              head_nxt = '0;
              tail_nxt = '0;
              wr_addr  = '0;
            end else if (in_mode == MODE_PUSH_FRONT) begin
              head_nxt = prev_idx(head_r, capacity_r);
              wr_addr  = head_nxt;
            end else begin
              tail_nxt = next_idx(tail_r, capacity_r);
              wr_addr  = tail_nxt;
            end
          end
        end
        MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
          if (empty) begin
            stat_nxt = STAT_UNDER;
            sel_nxt  = SEL_ONES;
          end else begin
            sel_nxt = SEL_MEM;
            if ((in_mode == MODE_POP_FRONT) || (in_mode == MODE_POP_BACK)) begin
              if (count_r == CAP_W'(1)) begin
                head_nxt  = '0;
                tail_nxt  = '0;
                count_nxt = '0;
              end else begin
                count_nxt = count_r - 1'b1;
                if (in_mode == MODE_POP_FRONT) begin
                  head_nxt = next_idx(head_r, capacity_r);
                end else begin
                  tail_nxt = prev_idx(tail_r, capacity_r);
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    if (cmd.op_go) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_INIT;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
    end else begin
      capacity_r <= capacity_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
    end
  end

  // Per-request result bookkeeping
  always_ff @(posedge clk) begin
    sel_r  <= sel_nxt;
    stat_r <= stat_nxt;
  end

  // Output register, flags reflect the state after the request
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (sel_r)
        SEL_MEM:  out_data_r <= rd_data_r;
        SEL_ONES: out_data_r <= '1;
        default:  out_data_r <= '0;
      endcase
      out_status_r <= stat_r;
      out_empty_r  <= (count_r == '0);
      out_full_r   <= (count_r >= capacity_r);
      out_occ_r    <= count_r;
    end
  end

  assign out_data      = out_data_r;
  assign out_status    = out_status_r;
  assign out_is_empty  = out_empty_r;
  assign out_is_full   = out_full_r;
  assign out_occupancy = out_occ_r;

endmodule

`default_nettype wire

[tb/sv/tb_circular_deque.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_deque
// Self-checking testbench for the circular deque. A driver offers push, pop
// and peek requests from a queue, a shadow deque predicts each result on
// acceptance, and a monitor compares every returned result field by field.
// Capacity is rewritten between phases while the deque is idle.
// ----------------------------------------------------------------------------

module tb_circular_deque;
  import cd_pkg::*;

  localparam int          SLOT_COUNT  = 16;
  localparam int          DRAIN_WAIT  = 6;
  localparam int          PHASE_ITEMS = 325;
  localparam int          LONG_HOLD   = 400;
  localparam int          HOLD_AFTER  = 600;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [31:0]       value;
  } deque_req_t;

  typedef struct {
    logic signed [31:0] data;
    logic [STAT_W-1:0]  status;
    logic               is_empty;
    logic               is_full;
    logic [CAP_W-1:0]   occupancy;
  } deque_result_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // DUT ports
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode   = '0;
  logic [31:0]         in_value  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [31:0]         out_data;
  logic [STAT_W-1:0]   out_status;
  logic                out_is_empty;
  logic                out_is_full;
  logic [CAP_W-1:0]    out_occupancy;
  logic                cfg_we    = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata = '0;

  circular_deque i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full),
    .out_occupancy (out_occupancy),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // request and result bookkeeping
  deque_req_t    pending_reqs[$];
  deque_result_t expected_results[$];
  int unsigned   fail_count    = 0;
  int unsigned   results_seen  = 0;
  int unsigned   send_idle_pct = 37;
  int unsigned   recv_idle_pct = 70;

  // shadow deque state
  logic [31:0]      shadow_slots[SLOT_COUNT];
  logic [3:0]       front_idx;
  logic [3:0]       back_idx;
  logic [CAP_W-1:0] held_words;
  logic [CAP_W-1:0] slots_in_use;

  function automatic logic [CAP_W-1:0] clip_capacity(logic [CAP_W-1:0] raw);
    if (raw == 0) return CAP_W'(1);
    if (raw > SLOT_COUNT) return CAP_W'(SLOT_COUNT);
    return raw;
  endfunction

  function automatic void clear_shadow();
    front_idx  = '0;
    back_idx   = '0;
    held_words = '0;
  endfunction

  // Apply one request to the shadow deque and return the result it gives
  function automatic deque_result_t deque_apply(logic [MODE_W-1:0] mode, logic [31:0] value);
    deque_result_t r;
    logic was_empty;
    logic was_full;
    logic at_front;
    r.data    = '0;
    r.status  = STAT_OK;
    was_empty = (held_words == 0);
    was_full  = (held_words >= slots_in_use);
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (was_full) begin
          r.status = STAT_OVER;
        end else begin
          if (was_empty) begin
            front_idx = '0;
            back_idx  = '0;
          end else if (mode == MODE_PUSH_FRONT) begin
            front_idx = (front_idx == 0) ? 4'(slots_in_use - 1) : front_idx - 4'd1;
          end else begin
            back_idx = (back_idx + 5'd1 >= slots_in_use) ? 4'd0 : back_idx + 4'd1;
          end
          shadow_slots[(mode == MODE_PUSH_FRONT) ? front_idx : back_idx] = value;
          held_words++;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
        if (was_empty) begin
          r.status = STAT_UNDER;
          r.data   = '1;
        end else begin
          at_front = (mode == MODE_POP_FRONT) || (mode == MODE_PEEK_FRONT);
          r.data   = shadow_slots[at_front ? front_idx : back_idx];
          if (mode == MODE_POP_FRONT || mode == MODE_POP_BACK) begin
            if (held_words == 1) begin
              clear_shadow();
            end else begin
              if (at_front)
                front_idx = (front_idx + 5'd1 >= slots_in_use) ? 4'd0 : front_idx + 4'd1;
              else
                back_idx = (back_idx == 0) ? 4'(slots_in_use - 1) : back_idx - 4'd1;
              held_words--;
            end
          end
        end
      end
      default: ;
    endcase
    r.is_empty  = (held_words == 0);
    r.is_full   = (held_words >= slots_in_use);
    r.occupancy = held_words;
    return r;
  endfunction

  // Driver: offer queued requests, predict on acceptance
  always @(posedge clk) begin
    deque_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(), deque_apply(in_mode, in_value));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs[0];
          pending_reqs.delete(0);
          in_valid <= 1'b1;
          in_mode  <= nxt.mode;
          in_value <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls plus one long hold-off to back up the deque
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result against the oldest prediction
  always @(posedge clk) begin
    deque_result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result: data %0d status %0d", $signed(out_data), out_status);
        fail_count++;
      end else begin
        e = expected_results[0];
        expected_results.delete(0);
        if (out_data !== e.data) begin
          $error("data: expected %0d, got %0d", e.data, $signed(out_data));
          fail_count++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          fail_count++;
        end
        if (out_is_empty !== e.is_empty) begin
          $error("is_empty: expected %0d, got %0d", e.is_empty, out_is_empty);
          fail_count++;
        end
        if (out_is_full !== e.is_full) begin
          $error("is_full: expected %0d, got %0d", e.is_full, out_is_full);
          fail_count++;
        end
        if (out_occupancy !== e.occupancy) begin
          $error("occupancy: expected %0d, got %0d", e.occupancy, out_occupancy);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [31:0] random_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_request(logic [MODE_W-1:0] mode, logic [31:0] value);
    deque_req_t r;
    r.mode  = mode;
    r.value = value;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Random traffic: fill bursts, drain bursts, mixed runs and a little noise
  task automatic queue_random(int unsigned total, int unsigned room);
    int unsigned added;
    int unsigned kind;
    int unsigned len;
    logic [MODE_W-1:0] m;
    added = 0;
    while (added < total) begin
      kind = $urandom_range(9);
      if (kind < 3) begin
        len = room + $urandom_range(2);
        repeat (len)
          add_request($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, random_word());
        added += len;
      end else if (kind < 6) begin
        len = room + $urandom_range(2);
        repeat (len) begin
          case ($urandom_range(7))
            0:       m = MODE_PEEK_FRONT;
            1:       m = MODE_PEEK_BACK;
            2, 3, 4: m = MODE_POP_FRONT;
            default: m = MODE_POP_BACK;
          endcase
          add_request(m, random_word());
        end
        added += len;
      end else if (kind < 9) begin
        len = $urandom_range(8, 1);
        repeat (len)
          add_request(MODE_W'($urandom_range(MODE_PEEK_BACK, MODE_PUSH_FRONT)),
                      random_word());
        added += len;
      end else begin
        add_request(MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)), random_word());
      end
    end
  endtask

  // Wait until every request is accepted and every result has returned
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || out_valid ||
           expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] raw);
    cfg_we    <= 1'b1;
    cfg_wdata <= raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    slots_in_use = clip_capacity(raw);
    clear_shadow();
  endtask

  // Main sequence
  initial begin
    logic [CAP_W-1:0] phase_cap[6];
    phase_cap[0] = 5'd16;
    phase_cap[1] = 5'd0;
    phase_cap[2] = 5'd31;
    phase_cap[3] = CAP_W'($urandom_range(15, 2));
    phase_cap[4] = 5'd1;
    phase_cap[5] = CAP_W'($urandom_range(8, 3));

    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    slots_in_use = CAP_W'(CAP_RESET);
    clear_shadow();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: underflow, push to empty, overflow, last pop, index wrap, spare modes
    write_capacity(5'd2);
    add_request(MODE_PEEK_FRONT, 32'h0);
    add_request(MODE_POP_BACK,   32'h0);
    add_request(MODE_PEEK_BACK,  32'h0);
    add_request(MODE_POP_FRONT,  32'h0);
    add_request(MODE_PUSH_FRONT, 32'h8000_0000);
    add_request(MODE_PUSH_BACK,  32'h7FFF_FFFF);
    add_request(MODE_PUSH_FRONT, 32'h0);
    add_request(MODE_PUSH_BACK,  32'hFFFF_FFFF);
    add_request(MODE_PEEK_FRONT, 32'h0);
    add_request(MODE_PEEK_BACK,  32'h0);
    add_request(MODE_POP_FRONT,  32'h0);
    add_request(MODE_POP_BACK,   32'h0);
    add_request(MODE_PUSH_BACK,  32'h0000_0001);
    add_request(MODE_PUSH_FRONT, 32'h5555_5555);
    add_request(MODE_POP_FRONT,  32'h0);
    add_request(MODE_PUSH_BACK,  32'hAAAA_AAAA);
    add_request(MODE_PEEK_BACK,  32'h0);
    add_request(MODE_SPARE_LO,   32'h1234_5678);
    add_request(MODE_SPARE_HI,   32'hFFFF_FFFF);
    add_request(MODE_POP_BACK,   32'h0);
    add_request(MODE_POP_BACK,   32'h0);
    add_request(MODE_PEEK_FRONT, 32'h0);
    wait_drained();

    // random phases: idle mix shifts every two phases, capacity every phase
    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0:       begin send_idle_pct = 37; recv_idle_pct = 70; end
        1:       begin send_idle_pct = 70; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      write_capacity(phase_cap[p]);
      queue_random(PHASE_ITEMS, 32'(clip_capacity(phase_cap[p])));
      wait_drained();
    end

    if (fail_count == 0)
      $display("circular_deque: match");
    else
      $display("circular_deque: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("circular_deque: mismatch");
    $finish;
  end

endmodule
